// ===== rtl/core/page_stats_predicate_filter_assert.svh =====
// Assertion macros for the page statistics filter
`ifndef PAGE_STATS_PREDICATE_FILTER_ASSERT_SVH
`define PAGE_STATS_PREDICATE_FILTER_ASSERT_SVH

// Implication checked on every clock, off during reset
`define PSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define PSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/psf_pkg.sv =====
`timescale 1ns / 1ps
package psf_pkg;
	localparam int MaxLiterals = 4;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;

	typedef enum logic [3:0] {
		OP_ISNULL = 4'd0, OP_NOTNULL = 4'd1, OP_EQ = 4'd2, OP_NE = 4'd3,
		OP_LT = 4'd4, OP_LE = 4'd5, OP_GT = 4'd6, OP_GE = 4'd7,
		OP_IN = 4'd8, OP_NOTIN = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		VT_BOOL = 3'd0, VT_INT32 = 3'd1, VT_INT64 = 3'd2, VT_FLT32 = 3'd3, VT_FLT64 = 3'd4
	} vtype_t;

	typedef enum logic [2:0] {
		CFG_OP = 3'd0, CFG_VTYPE = 3'd1, CFG_LIT0 = 3'd2, CFG_LIT1 = 3'd3,
		CFG_LIT2 = 3'd4, CFG_LIT3 = 3'd5, CFG_COUNT = 3'd6, CFG_NMASK = 3'd7
	} cfg_idx_t;

	// compare result: known, less, equal (greater = known & !lt & !eq)
	typedef struct packed {
		logic known;
		logic lt;
		logic eq;
	} cmp_t;

	// stage-1 prepared operand: order key plus flags
	typedef struct packed {
		logic [63:0] key;
		logic        nan;
		logic        len_ok;
	} opnd_t;

	// map raw bits to an unsigned order key for the given type
	function automatic opnd_t prep(input logic [2:0] vt, input logic [63:0] b,
			input logic [3:0] len, input logic is_lit);
		opnd_t r;
		r.key = '0;
		r.nan = 1'b0;
		r.len_ok = 1'b0;
		case (vt)
			VT_BOOL: begin
				r.key = {63'd0, is_lit ? (b != 64'd0) : (b[7:0] != 8'd0)};
				r.len_ok = len >= 4'd1;
			end
			VT_INT32: begin
				r.key = {32'd0, b[31] ^ 1'b1, b[30:0]};
				r.len_ok = len >= 4'd4;
			end
			VT_INT64: begin
				r.key = {b[63] ^ 1'b1, b[62:0]};
				r.len_ok = len >= 4'd8;
			end
			VT_FLT32: begin
				r.nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
				if (b[30:0] == 31'd0)
					r.key = {32'd0, 32'h8000_0000};
				else if (b[31])
					r.key = {32'd0, ~b[31:0]};
				else
					r.key = {32'd0, 1'b1, b[30:0]};
				r.len_ok = len >= 4'd4;
			end
			VT_FLT64: begin
				r.nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
				if (b[62:0] == 63'd0)
					r.key = 64'h8000_0000_0000_0000;
				else if (b[63])
					r.key = ~b;
				else
					r.key = {1'b1, b[62:0]};
				r.len_ok = len >= 4'd8;
			end
			default: r.len_ok = 1'b0;
		endcase
		if (is_lit)
			r.len_ok = 1'b1;
		return r;
	endfunction
endpackage

// ===== rtl/core/page_stats_predicate_filter.sv =====
`timescale 1ns / 1ps
// Path: a request moves through stage 1, stage 2 and the output register.
// Throughput: one page per cycle; three register stages (operand prep,
// compares, decision) advance together and hold as a whole on output stall.
// Reset: arst_n clears valid bits and loads register defaults (op isnull,
// type int32, literals zero, count one, no null literals).
`include "page_stats_predicate_filter_assert.svh"
module page_stats_predicate_filter
	import psf_pkg::*;
#(
	parameter int MAX_LITERALS = MaxLiterals
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	// all_null_page, null_count_known, null_count[30:0], min_bits[63:0],
	// min_length[3:0], max_bits[63:0], max_length[3:0], zero pad
	input  logic [175:0]        s_tdata,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	// page_matches, zero pad
	output logic [7:0]          m_tdata,
	output logic                m_tlast
);
	localparam int NL = MAX_LITERALS;

	logic [3:0]  op_q;
	logic [2:0]  vt_q;
	logic [63:0] lit_q [4];
	logic [2:0]  count_q;
	logic [3:0]  nmask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_ISNULL;
			vt_q <= VT_INT32;
			for (int i = 0; i < 4; i++) lit_q[i] <= '0;
			count_q <= 3'd1;
			nmask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OP:    op_q <= cfg_data[3:0];
				CFG_VTYPE: vt_q <= cfg_data[2:0];
				CFG_LIT0:  lit_q[0] <= cfg_data;
				CFG_LIT1:  lit_q[1] <= cfg_data;
				CFG_LIT2:  lit_q[2] <= cfg_data;
				CFG_LIT3:  lit_q[3] <= cfg_data;
				CFG_COUNT: count_q <= cfg_data[2:0];
				CFG_NMASK: nmask_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// literals in use, with saturation
	logic [NL-1:0] used;
	logic          any_null;
	always_comb begin
		for (int k = 0; k < NL; k++)
			used[k] = (k == 0) || (32'(count_q) > k);
		any_null = |(used & nmask_q[NL-1:0]);
	end

	logic adv;
	logic v_s1, v_s2, v_s3;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: operand keys
	opnd_t mn_s1, mx_s1;
	opnd_t lk_s1 [NL];
	logic  an_s1, hn_s1, kn_s1, last_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			an_s1 <= s_tdata[0];
			kn_s1 <= s_tdata[1];
			hn_s1 <= s_tdata[32:2] != 31'd0;
			mn_s1 <= prep(vt_q, s_tdata[96:33], s_tdata[100:97], 1'b0);
			mx_s1 <= prep(vt_q, s_tdata[164:101], s_tdata[168:165], 1'b0);
			for (int k = 0; k < NL; k++)
				lk_s1[k] <= prep(vt_q, lit_q[k], 4'd8, 1'b1);
			last_s1 <= s_tlast;
		end
	end

	// stage 2: compares of min and max against each literal
	cmp_t cmn_s2 [NL];
	cmp_t cmx_s2 [NL];
	logic an_s2, hn_s2, kn_s2, last_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			an_s2 <= an_s1;
			hn_s2 <= hn_s1;
			kn_s2 <= kn_s1;
			last_s2 <= last_s1;
			for (int k = 0; k < NL; k++) begin
				cmn_s2[k].known <= mn_s1.len_ok && !mn_s1.nan && !lk_s1[k].nan
					&& vt_q <= VT_FLT64;
				cmn_s2[k].lt <= mn_s1.key < lk_s1[k].key;
				cmn_s2[k].eq <= mn_s1.key == lk_s1[k].key;
				cmx_s2[k].known <= mx_s1.len_ok && !mx_s1.nan && !lk_s1[k].nan
					&& vt_q <= VT_FLT64;
				cmx_s2[k].lt <= mx_s1.key < lk_s1[k].key;
				cmx_s2[k].eq <= mx_s1.key == lk_s1[k].key;
			end
		end
	end

	// stage 3: decision
	logic [NL-1:0] meq;
	logic          m;
	always_comb begin
		for (int k = 0; k < NL; k++)
			meq[k] = !cmn_s2[k].known ||
				((cmn_s2[k].lt || cmn_s2[k].eq) &&
				(!cmx_s2[k].known || !cmx_s2[k].lt));
		m = 1'b1;
		case (op_t'(op_q))
			OP_ISNULL:  m = an_s2 || !kn_s2 || hn_s2;
			OP_NOTNULL: m = !an_s2;
			OP_EQ:      m = !nmask_q[0] && !an_s2 && meq[0];
			OP_NE:      m = !nmask_q[0] && !an_s2 && !(cmn_s2[0].known &&
				cmn_s2[0].eq && cmx_s2[0].known && cmx_s2[0].eq);
			OP_LT:      m = !nmask_q[0] && !an_s2 && (!cmn_s2[0].known || cmn_s2[0].lt);
			OP_LE:      m = !nmask_q[0] && !an_s2 && (!cmn_s2[0].known ||
				cmn_s2[0].lt || cmn_s2[0].eq);
			OP_GT:      m = !nmask_q[0] && !an_s2 && (!cmx_s2[0].known ||
				(!cmx_s2[0].lt && !cmx_s2[0].eq));
			OP_GE:      m = !nmask_q[0] && !an_s2 && (!cmx_s2[0].known || !cmx_s2[0].lt);
			OP_IN: begin
				if (an_s2) m = any_null;
				else if (any_null && (!kn_s2 || hn_s2)) m = 1'b1;
				else m = |(meq & used & ~nmask_q[NL-1:0]);
			end
			OP_NOTIN:   m = !any_null && !an_s2;
			default:    m = 1'b1;
		endcase
	end

	logic res_s3, last_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3 <= m;
			last_s3 <= last_s2;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata = {7'd0, res_s3};
	assign m_tlast = last_s3;

	`PSF_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(res_s3))
	`PSF_ASSERT_IMP(a_ready_adv, clk, arst_n, !m_tvalid, s_tready)
	`PSF_ASSERT_NEXT(a_pipe_move, clk, arst_n, adv && v_s2, v_s3)
endmodule
